/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lcdrf_pkg.sv */
`timescale 1ns / 1ps

package lcdrf_pkg;

  localparam int COORD_MAX_W     = 16;
  localparam int PANEL_W         = 13;
  localparam int COLOR_W         = 16;
  localparam int BYTE_W          = 8;
  localparam int CFG_IDX_W       = 1;
  localparam int Q_DEPTH         = 2;
  localparam int LCDRF_COORD_BITS = 16;

  localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = 13'd240;
  localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 13'd320;

  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'b1;

  localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW    = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h2C;

  typedef struct packed {
    logic                   tick;
    logic                   drop;
    logic                   empty;
    logic [COORD_MAX_W-1:0] col_start;
    logic [COORD_MAX_W-1:0] col_end;
    logic [COORD_MAX_W-1:0] row_start;
    logic [COORD_MAX_W-1:0] row_end;
    logic [PANEL_W-1:0]     width;
    logic [PANEL_W-1:0]     height;
    logic [COLOR_W-1:0]     color;
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CASET,
    ST_XS_HI,
    ST_XS_LO,
    ST_XE_HI,
    ST_XE_LO,
    ST_PASET,
    ST_YS_HI,
    ST_YS_LO,
    ST_YE_HI,
    ST_YE_LO,
    ST_RAMWR,
    ST_PIX_HI,
    ST_PIX_LO
  } seq_state_t;

endpackage

/* sv/lcdrf_front.sv */
`timescale 1ns / 1ps

module lcdrf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lcdrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdrf_pkg::PANEL_W-1:0]    cfg_data,
  input  logic                             in_valid,
  input  logic                             q_full,
  input  logic                             in_action,
  input  logic [lcdrf_pkg::COORD_MAX_W-1:0] in_x_origin,
  input  logic [lcdrf_pkg::COORD_MAX_W-1:0] in_y_origin,
  input  logic [lcdrf_pkg::COORD_MAX_W-1:0] in_rect_width,
  input  logic [lcdrf_pkg::COORD_MAX_W-1:0] in_rect_height,
  input  logic [lcdrf_pkg::COLOR_W-1:0]    in_fill_color,
  output logic                             push,
  output lcdrf_pkg::req_t                  req
);
  import lcdrf_pkg::*;

  logic [PANEL_W-1:0]     panel_width_r;
  logic [PANEL_W-1:0]     panel_height_r;
  logic                   off_panel;
  logic [COORD_MAX_W:0]   x_sum;
  logic [COORD_MAX_W:0]   y_sum;
  logic [PANEL_W-1:0]     w_clip;
  logic [PANEL_W-1:0]     h_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= PANEL_WIDTH_RST;
      panel_height_r <= PANEL_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PANEL_WIDTH:  panel_width_r  <= cfg_data;
        REG_PANEL_HEIGHT: panel_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    off_panel = (in_x_origin >= COORD_MAX_W'(panel_width_r)) ||
                (in_y_origin >= COORD_MAX_W'(panel_height_r));
    x_sum = (COORD_MAX_W+1)'(in_x_origin) + (COORD_MAX_W+1)'(in_rect_width);
    y_sum = (COORD_MAX_W+1)'(in_y_origin) + (COORD_MAX_W+1)'(in_rect_height);
    w_clip = (x_sum > (COORD_MAX_W+1)'(panel_width_r)) ?
             panel_width_r - in_x_origin[PANEL_W-1:0] : in_rect_width[PANEL_W-1:0];
    h_clip = (y_sum > (COORD_MAX_W+1)'(panel_height_r)) ?
             panel_height_r - in_y_origin[PANEL_W-1:0] : in_rect_height[PANEL_W-1:0];

    req.tick      = in_action;
    req.drop      = off_panel;
    req.empty     = (w_clip == '0) || (h_clip == '0);
    req.col_start = in_x_origin;
    req.row_start = in_y_origin;
    req.col_end   = in_x_origin + COORD_MAX_W'(w_clip) - COORD_MAX_W'(1);
    req.row_end   = in_y_origin + COORD_MAX_W'(h_clip) - COORD_MAX_W'(1);
    req.width     = w_clip;
    req.height    = h_clip;
    req.color     = in_fill_color;
  end

  assign push = in_valid && !q_full;

endmodule

/* sv/lcdrf_queue.sv */
`timescale 1ns / 1ps

module lcdrf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcdrf_pkg::req_t push_data,
  input  logic            pop,
  output logic            head_valid,
  output lcdrf_pkg::req_t head_data,
  output logic            full
);
  import lcdrf_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  req_t             entries_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_W'(Q_DEPTH));
  assign head_data  = entries_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/lcdrf_back.sv */
`timescale 1ns / 1ps

module lcdrf_back #(
  parameter int COORD_BITS = lcdrf_pkg::LCDRF_COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  lcdrf_pkg::req_t             head_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lcdrf_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_is_data,
  output logic                        out_last
);
  import lcdrf_pkg::*;

  seq_state_t             state_r, state_nxt;
  logic [COORD_BITS-1:0]  col_start_r, col_end_r, row_start_r, row_end_r;
  logic [COLOR_W-1:0]     color_r;
  logic                   empty_r;
  logic [PANEL_W-1:0]     width_r;
  logic [PANEL_W-1:0]     cols_left_r, cols_left_nxt;
  logic [PANEL_W-1:0]     rows_left_r, rows_left_nxt;
  logic                   out_valid_r;
  logic [BYTE_W-1:0]      out_byte_r;
  logic                   out_is_data_r;
  logic                   out_last_r;

  logic                   needs_out;
  logic                   slot_free;
  logic                   load;
  logic                   emit;
  logic [BYTE_W-1:0]      res_byte;
  logic                   res_is_data;
  logic                   res_last;
  logic [COORD_MAX_W-1:0] cs16, ce16, rs16, re16;

  assign cs16 = COORD_MAX_W'(col_start_r);
  assign ce16 = COORD_MAX_W'(col_end_r);
  assign rs16 = COORD_MAX_W'(row_start_r);
  assign re16 = COORD_MAX_W'(row_end_r);

  assign needs_out = head_valid && head_data.tick && (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = head_valid && (!needs_out || slot_free);
  assign emit      = pop && needs_out;
  assign load      = pop && !head_data.tick && !head_data.drop && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cols_left_nxt = cols_left_r;
    rows_left_nxt = rows_left_r;
    res_byte      = '0;
    res_is_data   = 1'b1;
    res_last      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt     = ST_CASET;
          cols_left_nxt = head_data.width;
          rows_left_nxt = head_data.height;
        end
      end
      ST_CASET: begin
        res_byte    = CMD_COLUMN;
        res_is_data = 1'b0;
        if (emit) state_nxt = ST_XS_HI;
      end
      ST_XS_HI: begin
        res_byte = cs16[15:8];
        if (emit) state_nxt = ST_XS_LO;
      end
      ST_XS_LO: begin
        res_byte = cs16[7:0];
        if (emit) state_nxt = ST_XE_HI;
      end
      ST_XE_HI: begin
        res_byte = ce16[15:8];
        if (emit) state_nxt = ST_XE_LO;
      end
      ST_XE_LO: begin
        res_byte = ce16[7:0];
        if (emit) state_nxt = ST_PASET;
      end
      ST_PASET: begin
        res_byte    = CMD_ROW;
        res_is_data = 1'b0;
        if (emit) state_nxt = ST_YS_HI;
      end
      ST_YS_HI: begin
        res_byte = rs16[15:8];
        if (emit) state_nxt = ST_YS_LO;
      end
      ST_YS_LO: begin
        res_byte = rs16[7:0];
        if (emit) state_nxt = ST_YE_HI;
      end
      ST_YE_HI: begin
        res_byte = re16[15:8];
        if (emit) state_nxt = ST_YE_LO;
      end
      ST_YE_LO: begin
        res_byte = re16[7:0];
        if (emit) state_nxt = ST_RAMWR;
      end
      ST_RAMWR: begin
        res_byte    = CMD_WRITE;
        res_is_data = 1'b0;
        res_last    = empty_r;
        if (emit) state_nxt = empty_r ? ST_IDLE : ST_PIX_HI;
      end
      ST_PIX_HI: begin
        res_byte = color_r[15:8];
        if (emit) state_nxt = ST_PIX_LO;
      end
      ST_PIX_LO: begin
        res_byte = color_r[7:0];
        res_last = (cols_left_r == PANEL_W'(1)) && (rows_left_r == PANEL_W'(1));
        if (emit) begin
          if (res_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PIX_HI;
            if (cols_left_r == PANEL_W'(1)) begin
              cols_left_nxt = width_r;
              rows_left_nxt = rows_left_r - PANEL_W'(1);
            end else begin
              cols_left_nxt = cols_left_r - PANEL_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cols_left_r <= cols_left_nxt;
    rows_left_r <= rows_left_nxt;
    if (load) begin
      col_start_r <= head_data.col_start[COORD_BITS-1:0];
      col_end_r   <= head_data.col_end[COORD_BITS-1:0];
      row_start_r <= head_data.row_start[COORD_BITS-1:0];
      row_end_r   <= head_data.row_end[COORD_BITS-1:0];
      color_r     <= head_data.color;
      empty_r     <= head_data.empty;
      width_r     <= head_data.width;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r    <= res_byte;
      out_is_data_r <= res_is_data;
      out_last_r    <= res_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_is_data_r;
  assign out_last    = out_last_r;

endmodule

/* sv/lcd_rect_fill_sequencer_unit.sv */
`timescale 1ns / 1ps
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------------
// input     | in_valid / in_stall  | in_action, in_x_origin, in_y_origin,
//           |                      | in_rect_width, in_rect_height, in_fill_color
// result    | out_valid / out_stall| out_byte, out_is_data, out_last
// config    | cfg_we               | cfg_index, cfg_data
//
// One item is accepted per cycle sustained while in_stall is low; a result for an accepted
// tick passes through the two-entry queue and the output register.
// A request or an idle tick is popped as soon as it heads the queue and yields no transfer.
// While out_stall holds a pending byte, ticks for a busy sequencer queue up; in_stall rises after two items.
// Reset is synchronous: the queue empties, the sequencer goes idle and the panel size
// returns to 240 by 320.

module lcd_rect_fill_sequencer_unit #(
  parameter int COORD_BITS = lcdrf_pkg::LCDRF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lcdrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcdrf_pkg::PANEL_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [lcdrf_pkg::COORD_MAX_W-1:0] in_x_origin,
  input  logic [lcdrf_pkg::COORD_MAX_W-1:0] in_y_origin,
  input  logic [lcdrf_pkg::COORD_MAX_W-1:0] in_rect_width,
  input  logic [lcdrf_pkg::COORD_MAX_W-1:0] in_rect_height,
  input  logic [lcdrf_pkg::COLOR_W-1:0]     in_fill_color,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lcdrf_pkg::BYTE_W-1:0]      out_byte,
  output logic                              out_is_data,
  output logic                              out_last
);
  import lcdrf_pkg::*;

  logic push;
  req_t push_req;
  logic q_full;
  logic head_valid;
  req_t head_req;
  logic pop;

  lcdrf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .q_full         (q_full),
    .in_action      (in_action),
    .in_x_origin    (in_x_origin),
    .in_y_origin    (in_y_origin),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_fill_color  (in_fill_color),
    .push           (push),
    .req            (push_req)
  );

  lcdrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_req),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_req),
    .full       (q_full)
  );

  lcdrf_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_data   (head_req),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_is_data (out_is_data),
    .out_last    (out_last)
  );

  assign in_stall = q_full;

`include "assert_macros.svh"

  `ASSERT_CLK(a_cmd_codes, (out_valid && !out_is_data) |-> (out_byte == CMD_COLUMN || out_byte == CMD_ROW || out_byte == CMD_WRITE), "command byte with unknown code")
  `ASSERT_CLK(a_last_cmd, (out_valid && out_last && !out_is_data) |-> (out_byte == CMD_WRITE), "final command byte is not the memory write")
  `ASSERT_NEXT(a_push_lands, (in_valid && !in_stall), head_valid, "accepted item missing from queue")

endmodule
